### design/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants for the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    // one message item: byte plus framing
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } msg_t;

    // one digest item
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [5:0] LAST_FILL     = 6'd63;
    localparam logic [5:0] LEN_POS       = 6'd56;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;
    localparam logic [63:0] BYTE_BITS    = 64'd8;

    // initial hash values h0..h7
    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] r;
        case (idx)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    // round constant table
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] r;
        case (idx)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

### design/sha256_message_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hasher
// Byte-serial SHA-256: collects message bytes, pads, compresses with one
// round unit and returns the eight digest words.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload            | item
//  ---------+---------------------------+--------------------+-----------------
//  message  | msg_valid / msg_ready     | msg_item  (msg_t)  | one byte / end
//  digest   | dig_valid / dig_ready     | dig_item  (dig_t)  | one digest word
//
//  A byte that does not fill the block is taken and the hasher stays ready for
//  the next one. The 64th byte of a block starts the compression: the shared
//  round unit runs the rounds, then ST_ADD folds the working words into the
//  chaining words. An end item then pushes the 0x80 mark, zeros and the 8
//  length bytes one per cycle into the block (one or two blocks), each full
//  block followed by its compression, then 8 digest items.
//  msg_ready is high only while waiting for bytes; the digest words are read
//  from the chaining registers and hold while dig_ready is low.
//  Reset loads the initial hash values and clears fill count and bit length.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               msg_valid,
    output logic               msg_ready,
    input  sha256_pkg::msg_t   msg_item,
    output logic               dig_valid,
    input  logic               dig_ready,
    output sha256_pkg::dig_t   dig_item
);

    // --- state ---------------------------------------------------------------
    sha256_pkg::state_t state_reg, state_next;

    // Block buffer and message schedule share one 16-word shift line:
    // bytes shift in at the bottom, rounds shift words out at the top.
    logic [511:0] sched_reg, sched_next;
    logic [31:0]  chain_reg [8];
    logic [31:0]  chain_next [8];
    logic [31:0]  wv_reg [8];       // a..h
    logic [31:0]  wv_next [8];
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  len_reg, len_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [2:0]   idx_reg, idx_next;
    logic         end_pend_reg, end_pend_next;   // padding owed after this block
    logic         mark_sent_reg, mark_sent_next;
    logic         len_phase_reg, len_phase_next;
    logic         done_reg, done_next;           // final block compressed next

    logic         push_en;
    logic [7:0]   push_byte;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned s);
        return (x >> s) | (x << (32 - s));
    endfunction

    // --- round unit ------------------------------------------------------------
    logic [31:0] w_cur, w1, w9, w14, w_new;
    logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

    assign w_cur = sched_reg[511:480];
    assign w1    = sched_reg[479:448];
    assign w9    = sched_reg[223:192];
    assign w14   = sched_reg[63:32];

    // next schedule word W[t+16], pushed every round
    assign w_new = w_cur + w9
                 + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3))
                 + (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));

    assign big_s1 = rotr(wv_reg[4], 6) ^ rotr(wv_reg[4], 11) ^ rotr(wv_reg[4], 25);
    assign big_s0 = rotr(wv_reg[0], 2) ^ rotr(wv_reg[0], 13) ^ rotr(wv_reg[0], 22);
    assign ch     = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
    assign maj    = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                  ^ (wv_reg[1] & wv_reg[2]);
    assign t1     = wv_reg[7] + big_s1 + ch + sha256_pkg::round_k(rnd_reg) + w_cur;
    assign t2     = big_s0 + maj;

    // --- digest output -----------------------------------------------------------
    assign dig_item.digest_word = chain_reg[idx_reg];
    assign dig_item.word_index  = idx_reg;
    assign dig_item.last_word   = (idx_reg == sha256_pkg::LAST_WORD_IDX);

    // --- sequencer ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        sched_next     = sched_reg;
        chain_next     = chain_reg;
        wv_next        = wv_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        rnd_next       = rnd_reg;
        idx_next       = idx_reg;
        end_pend_next  = end_pend_reg;
        mark_sent_next = mark_sent_reg;
        len_phase_next = len_phase_reg;
        done_next      = done_reg;
        push_en        = 1'b0;
        push_byte      = 8'h00;
        msg_ready      = 1'b0;
        dig_valid      = 1'b0;

        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_valid)
                begin
                    end_pend_next = msg_item.end_of_message;
                    if (msg_item.has_byte)
                    begin
                        push_en   = 1'b1;
                        push_byte = msg_item.data_byte;
                        len_next  = len_reg + sha256_pkg::BYTE_BITS;
                    end
                    if (msg_item.has_byte && fill_reg == sha256_pkg::LAST_FILL)
                        state_next = sha256_pkg::ST_ROUND;
                    else if (msg_item.end_of_message)
                        state_next = sha256_pkg::ST_PAD;
                end
            end

            sha256_pkg::ST_PAD:
            begin
                push_en = 1'b1;
                if (!mark_sent_reg)
                begin
                    push_byte      = sha256_pkg::PAD_MARK;
                    mark_sent_next = 1'b1;
                end
                else if (len_phase_reg || fill_reg == sha256_pkg::LEN_POS)
                begin
                    // length goes out most significant byte first
                    push_byte      = len_reg[63:56];
                    len_next       = {len_reg[55:0], 8'h00};
                    len_phase_next = 1'b1;
                    if (fill_reg == sha256_pkg::LAST_FILL)
                        done_next = 1'b1;
                end
                if (fill_reg == sha256_pkg::LAST_FILL)
                    state_next = sha256_pkg::ST_ROUND;
            end

            sha256_pkg::ST_ROUND:
            begin
                sched_next = {sched_reg[479:0], w_new};
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == sha256_pkg::LAST_ROUND)
                    state_next = sha256_pkg::ST_ADD;
            end

            sha256_pkg::ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    chain_next[i] = chain_reg[i] + wv_reg[i];
                if (done_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = sha256_pkg::ST_OUT;
                end
                else if (end_pend_reg)
                    state_next = sha256_pkg::ST_PAD;
                else
                    state_next = sha256_pkg::ST_IDLE;
            end

            sha256_pkg::ST_OUT:
            begin
                dig_valid = 1'b1;
                if (dig_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha256_pkg::LAST_WORD_IDX)
                    begin
                        // start over for the next message
                        for (int i = 0; i < 8; i++)
                            chain_next[i] = sha256_pkg::init_h(3'(i));
                        len_next       = '0;
                        fill_next      = '0;
                        end_pend_next  = 1'b0;
                        mark_sent_next = 1'b0;
                        len_phase_next = 1'b0;
                        done_next      = 1'b0;
                        state_next     = sha256_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase

        if (push_en)
        begin
            sched_next = {sched_reg[503:0], push_byte};
            fill_next  = fill_reg + 6'd1;
        end

        // a full block starts its compression from the chaining words
        if (state_next == sha256_pkg::ST_ROUND && state_reg != sha256_pkg::ST_ROUND)
        begin
            wv_next  = chain_reg;
            rnd_next = '0;
        end
    end

    // --- registers -----------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha256_pkg::ST_IDLE;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha256_pkg::init_h(3'(i));
            fill_reg      <= '0;
            len_reg       <= '0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            end_pend_reg  <= 1'b0;
            mark_sent_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            rnd_reg       <= rnd_next;
            idx_reg       <= idx_next;
            end_pend_reg  <= end_pend_next;
            mark_sent_reg <= mark_sent_next;
            len_phase_reg <= len_phase_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        wv_reg    <= wv_next;
    end

endmodule

### design/sha256_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_chk
// Port-level checks for the SHA-256 message hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             msg_valid,
    input logic             msg_ready,
    input sha256_pkg::msg_t msg_item,
    input logic             dig_valid,
    input logic             dig_ready,
    input sha256_pkg::dig_t dig_item
);

    // a stalled digest item holds
    a_dig_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_ready |=> dig_valid && $stable(dig_item))
        else $error("digest item changed while stalled");

    // no bytes are taken while the digest is going out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(msg_ready && dig_valid))
        else $error("message taken during digest output");

    // words come in order 0..7
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_ready && !dig_item.last_word |=>
            dig_valid && dig_item.word_index == 3'($past(dig_item.word_index) + 3'd1))
        else $error("digest word out of order");

    // digest ends after the last word
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && dig_ready && dig_item.last_word |=> !dig_valid)
        else $error("digest output ran past the last word");

    // an accepted end item is followed by msg_ready low
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && msg_item.end_of_message |=> !msg_ready)
        else $error("intake continued after end of message");

endmodule

bind sha256_message_hasher sha256_chk u_sha256_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg_item  (msg_item),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig_item  (dig_item)
);
